@@ rtl/brf_pkg.sv @@
// ----------------------------------------------------------------------------
// brf_pkg
// Shared types and operation codes for the byte ring FIFO with peek.
// ----------------------------------------------------------------------------
package brf_pkg;

  // Operation codes carried on in_mode.
  localparam logic [1:0] MODE_PUSH  = 2'd0;
  localparam logic [1:0] MODE_POP   = 2'd1;
  localparam logic [1:0] MODE_PEEK  = 2'd2;
  localparam logic [1:0] MODE_CLEAR = 2'd3;

  // Fixed field widths.
  localparam int unsigned CAP_W   = 9;
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned BYTE_W  = 8;

  localparam logic [CAP_W-1:0]   CAP_RESET = 9'd256;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;

  // Sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_READ
  } brf_state_t;

endpackage

@@ rtl/byte_ring_fifo_with_peek.sv @@
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_peek
// Byte ring FIFO with full flag, peek at an offset and per-transfer beat count.
// ----------------------------------------------------------------------------
// Push, clear, refused: result valid the cycle after accept; next beat waits only on out_stall.
// Accepted pop and peek: next beat held off until the registered read port of
//   the byte store returns (read issued at accept, data captured the next cycle).
// Reset (synchronous, rst_n low): indices, full flag, beat count and output
//   valid clear; capacity returns to 256. Byte store contents are not cleared.
module byte_ring_fifo_with_peek
  import brf_pkg::*;
#(
  parameter int unsigned DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  // input beats
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_mode,
  input  logic [BYTE_W-1:0]  in_data_in,
  input  logic [BYTE_W-1:0]  in_offset,
  input  logic               in_last_of_call,
  // result beats
  output logic               out_valid,
  input  logic               out_stall,
  output logic [BYTE_W-1:0]  out_data_out,
  output logic               out_accepted,
  output logic [COUNT_W-1:0] out_call_count,
  output logic [CAP_W-1:0]   out_occupancy,
  output logic               out_full_res,
  output logic               out_empty_res,
  output logic               out_last,
  // capacity register
  input  logic               cfg_we,
  input  logic [CAP_W-1:0]   cfg_wdata
);

  // AW: store index; CW: holds values up to DEPTH; SW: common compare width.
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned SW = (CW > CAP_W) ? CW : CAP_W;
  localparam int unsigned CAP_RST_VAL = (DEPTH < 256) ? DEPTH : 256;
  localparam logic [CW-1:0] CAP_ACT_RST = CW'(CAP_RST_VAL);
  localparam logic [SW-1:0] DEPTH_S     = SW'(DEPTH);

  // Occupancy from indices, full flag and active capacity.
  function automatic logic [CW-1:0] fill_of(
    input logic          full,
    input logic [AW-1:0] widx,
    input logic [AW-1:0] ridx,
    input logic [CW-1:0] cap
  );
    logic [CW-1:0] w;
    logic [CW-1:0] r;
    w = CW'(widx);
    r = CW'(ridx);
    if (full) begin
      return cap;
    end else if (w >= r) begin
      return w - r;
    end else begin
      return w + cap - r;
    end
  endfunction

  // Control state
  brf_state_t         state_r,    state_nxt;
  logic [AW-1:0]      wr_idx_r,   wr_idx_nxt;
  logic [AW-1:0]      rd_idx_r,   rd_idx_nxt;
  logic               full_r,     full_nxt;
  logic [COUNT_W-1:0] count_r,    count_nxt;
  logic [CAP_W-1:0]   capacity_r, capacity_nxt;
  logic [CW-1:0]      cap_act_r,  cap_act_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Result payload
  logic [BYTE_W-1:0]  out_data_r;
  logic               out_acc_r;
  logic [COUNT_W-1:0] out_count_r;
  logic [CAP_W-1:0]   out_occ_r;
  logic               out_full_r;
  logic               out_empty_r;
  logic               out_last_r;

  // Datapath
  logic               in_accept;
  logic               out_free;
  logic               acc;
  logic               rd_pend;
  logic [CW-1:0]      fill_cur;
  logic [CW-1:0]      fill_new;
  logic [CW-1:0]      wr_p1;
  logic [CW-1:0]      rd_p1;
  logic [AW-1:0]      wr_adv;
  logic [AW-1:0]      rd_adv;
  logic [SW-1:0]      pos_sum;
  logic [SW-1:0]      pos_wrap;
  logic [SW-1:0]      cap_clamp;
  logic [COUNT_W-1:0] count_inc;
  logic               ram_we;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [BYTE_W-1:0]  ram_rdata;

  // One byte store; reads and writes happen only at accept, and a read
  // result is taken in the following cycle while input is held off, so a
  // write and a read never touch the store in the same cycle.
  brf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (wr_idx_r),
    .wr_data (in_data_in),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Output slot is free when empty or being drained this cycle.
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || !out_free;
  assign in_accept = in_valid && !in_stall;

  // Index advance with wrap at the active capacity.
  assign wr_p1  = CW'(wr_idx_r) + CW'(1);
  assign rd_p1  = CW'(rd_idx_r) + CW'(1);
  assign wr_adv = (wr_p1 >= cap_act_r) ? '0 : wr_p1[AW-1:0];
  assign rd_adv = (rd_p1 >= cap_act_r) ? '0 : rd_p1[AW-1:0];

  // Peek position: offset is below occupancy, so one subtract wraps it.
  assign fill_cur = fill_of(full_r, wr_idx_r, rd_idx_r, cap_act_r);
  assign pos_sum  = SW'(rd_idx_r) + SW'(in_offset);
  assign pos_wrap = (pos_sum >= SW'(cap_act_r)) ? pos_sum - SW'(cap_act_r) : pos_sum;

  // Capacity clamp to 1..DEPTH, applied on clear.
  always_comb begin
    if (capacity_r == '0) begin
      cap_clamp = SW'(1);
    end else if (SW'(capacity_r) > DEPTH_S) begin
      cap_clamp = DEPTH_S;
    end else begin
      cap_clamp = SW'(capacity_r);
    end
  end

  // Operation decode, next state and result fields.
  always_comb begin
    state_nxt    = state_r;
    wr_idx_nxt   = wr_idx_r;
    rd_idx_nxt   = rd_idx_r;
    full_nxt     = full_r;
    cap_act_nxt  = cap_act_r;
    capacity_nxt = cfg_we ? cfg_wdata : capacity_r;
    acc          = 1'b0;
    rd_pend      = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = rd_idx_r;

    case (in_mode)
      MODE_PUSH: begin
        if (!full_r) begin
          acc        = 1'b1;
          ram_we     = in_accept;
          wr_idx_nxt = wr_adv;
          // Write index meeting read index fills the ring.
          full_nxt   = (wr_adv == rd_idx_r);
        end
      end
      MODE_POP: begin
        if (full_r || (wr_idx_r != rd_idx_r)) begin
          acc        = 1'b1;
          rd_pend    = 1'b1;
          ram_re     = in_accept;
          rd_idx_nxt = rd_adv;
          full_nxt   = 1'b0;
        end
      end
      MODE_PEEK: begin
        if (SW'(in_offset) < SW'(fill_cur)) begin
          acc       = 1'b1;
          rd_pend   = 1'b1;
          ram_re    = in_accept;
          ram_raddr = pos_wrap[AW-1:0];
        end
      end
      MODE_CLEAR: begin
        wr_idx_nxt  = '0;
        rd_idx_nxt  = '0;
        full_nxt    = 1'b0;
        cap_act_nxt = cap_clamp[CW-1:0];
      end
      default: begin
        acc = 1'b0;
      end
    endcase

    // Drop pointer updates unless the beat is really taken.
    if (!in_accept) begin
      wr_idx_nxt  = wr_idx_r;
      rd_idx_nxt  = rd_idx_r;
      full_nxt    = full_r;
      cap_act_nxt = cap_act_r;
    end

    fill_new  = fill_of(full_nxt, wr_idx_nxt, rd_idx_nxt, cap_act_nxt);
    count_inc = (acc && (count_r < COUNT_MAX)) ? count_r + COUNT_W'(1) : count_r;

    count_nxt = count_r;
    if (in_accept) begin
      count_nxt = in_last_of_call ? '0 : count_inc;
    end

    // Output valid: drain, then load on accept or on returning read data.
    out_valid_nxt = out_valid_r && out_stall;
    if (in_accept) begin
      out_valid_nxt = !rd_pend;
      state_nxt     = rd_pend ? ST_READ : ST_IDLE;
    end else if (state_r == ST_READ) begin
      out_valid_nxt = 1'b1;
      state_nxt     = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      full_r      <= 1'b0;
      count_r     <= '0;
      capacity_r  <= CAP_RESET;
      cap_act_r   <= CAP_ACT_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_idx_r    <= wr_idx_nxt;
      rd_idx_r    <= rd_idx_nxt;
      full_r      <= full_nxt;
      count_r     <= count_nxt;
      capacity_r  <= capacity_nxt;
      cap_act_r   <= cap_act_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload: load status on accept, fill in the byte when read data returns.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r  <= '0;
      out_acc_r   <= acc;
      out_count_r <= count_inc;
      out_occ_r   <= CAP_W'(fill_new);
      out_full_r  <= full_nxt;
      out_empty_r <= (fill_new == '0);
      out_last_r  <= in_last_of_call;
    end else if (state_r == ST_READ) begin
      out_data_r  <= ram_rdata;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data_out   = out_data_r;
  assign out_accepted   = out_acc_r;
  assign out_call_count = out_count_r;
  assign out_occupancy  = out_occ_r;
  assign out_full_res   = out_full_r;
  assign out_empty_res  = out_empty_r;
  assign out_last       = out_last_r;

endmodule

@@ rtl/brf_ram.sv @@
// ----------------------------------------------------------------------------
// brf_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module brf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
